// ===== rtl/calt_pkg.sv =====
// Shared types, codes and constants for the compacting record table.
package calt_pkg;

    localparam int CAPACITY = 32;
    localparam int REC_W    = 128;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_LIST   = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Result kinds the controller asks the datapath to build
    localparam logic [2:0] EM_REC   = 3'd0;
    localparam logic [2:0] EM_APP   = 3'd1;
    localparam logic [2:0] EM_FULL  = 3'd2;
    localparam logic [2:0] EM_MISS  = 3'd3;
    localparam logic [2:0] EM_EMPTY = 3'd4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] key;
        logic [63:0]        name_tag;
        logic [31:0]        price_cents;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_key;
        logic [63:0]        out_name_tag;
        logic [31:0]        out_price_cents;
        logic [5:0]         entry_index;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] key;
        logic [63:0]        name_tag;
        logic [31:0]        price_cents;
    } t_rec;

    typedef struct packed {
        logic       load_in;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_en;
        logic       rd_next;
        logic       wr_append;
        logic       wr_shift;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       emit;
        logic [2:0] emit_kind;
        logic       emit_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_op;
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       idx_end;
        logic       idx_last;
        logic       key_match;
        logic       out_free;
    } t_stat;

endpackage

// ===== rtl/calt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module calt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/calt_dp.sv =====
// Datapath: input latch, record RAM, entry count, walk index and result register.
module calt_dp #(
    parameter int CAPACITY = calt_pkg::CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  calt_pkg::t_in_item  i_in_item,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output calt_pkg::t_out_item o_out_item,
    input  calt_pkg::t_cmd      i_cmd,
    output calt_pkg::t_stat     o_stat
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    calt_pkg::t_in_item  r_in;
    calt_pkg::t_out_item r_out, n_out;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    idx_plus1;
    calt_pkg::t_rec      rd_rec;
    calt_pkg::t_rec      in_rec;
    logic [calt_pkg::REC_W-1:0] ram_rdata;
    logic [calt_pkg::REC_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;

    assign idx_plus1 = r_idx + CNT_W'(1);
    assign rd_rec    = calt_pkg::t_rec'(ram_rdata);
    assign in_rec    = '{key: r_in.key, name_tag: r_in.name_tag,
                         price_cents: r_in.price_cents};

    // Append writes at the tail, the shift writes the read-ahead record one place down
    assign ram_waddr = i_cmd.wr_append ? r_count[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
    assign ram_wdata = i_cmd.wr_append ? in_rec : ram_rdata;
    assign ram_raddr = i_cmd.rd_next ? idx_plus1[ADDR_W-1:0] : r_idx[ADDR_W-1:0];

    calt_ram #(
        .WIDTH (calt_pkg::REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_append | i_cmd.wr_shift),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= idx_plus1;
        end
    end

    always_comb begin
        n_out = '0;
        unique case (i_cmd.emit_kind)
            calt_pkg::EM_REC: begin
                n_out.status          = calt_pkg::ST_OK;
                n_out.out_key         = rd_rec.key;
                n_out.out_name_tag    = rd_rec.name_tag;
                n_out.out_price_cents = rd_rec.price_cents;
                n_out.entry_index     = 6'(r_idx);
            end
            calt_pkg::EM_APP: begin
                n_out.status          = calt_pkg::ST_OK;
                n_out.out_key         = r_in.key;
                n_out.out_name_tag    = r_in.name_tag;
                n_out.out_price_cents = r_in.price_cents;
                n_out.entry_index     = 6'(r_count);
            end
            calt_pkg::EM_FULL: begin
                n_out.status  = calt_pkg::ST_FULL;
                n_out.out_key = r_in.key;
            end
            calt_pkg::EM_MISS: begin
                n_out.status  = calt_pkg::ST_MISS;
                n_out.out_key = r_in.key;
            end
            calt_pkg::EM_EMPTY: begin
                n_out.status = calt_pkg::ST_EMPTY;
            end
            default: begin
                n_out.status = calt_pkg::ST_OK;
            end
        endcase
        n_out.last = i_cmd.emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Arriving opcode for dispatch in idle, latched one for the rest of the item
    assign o_stat.in_op     = i_in_item.opcode;
    assign o_stat.op        = r_in.opcode;
    assign o_stat.full      = (r_count == CNT_W'(CAPACITY));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.idx_end   = (r_idx == r_count);
    assign o_stat.idx_last  = (idx_plus1 == r_count);
    assign o_stat.key_match = (rd_rec.key == r_in.key);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule

// ===== rtl/calt_ctrl.sv =====
// Controller: sequences append, list, scan and the compacting shift.
module calt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  calt_pkg::t_stat i_stat,
    output calt_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_APP   = 4'd1;
    localparam logic [3:0] S_LIST  = 4'd2;
    localparam logic [3:0] S_LS_EM = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_CHECK = 4'd5;
    localparam logic [3:0] S_SH_RD = 4'd6;
    localparam logic [3:0] S_SH_WR = 4'd7;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    unique case (i_stat.in_op)
                        calt_pkg::OP_APPEND: n_state = S_APP;
                        calt_pkg::OP_LIST:   n_state = S_LIST;
                        default:             n_state = S_SCAN;
                    endcase
                end
            end
            S_APP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.emit_kind = calt_pkg::EM_FULL;
                    end else begin
                        o_cmd.emit_kind = calt_pkg::EM_APP;
                        o_cmd.wr_append = 1'b1;
                        o_cmd.cnt_inc   = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_stat.empty) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = calt_pkg::EM_EMPTY;
                        o_cmd.emit_last = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_LS_EM;
                end
            end
            S_LS_EM: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = calt_pkg::EM_REC;
                    o_cmd.emit_last = i_stat.idx_last;
                    if (i_stat.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_LIST;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.idx_end) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = calt_pkg::EM_MISS;
                        o_cmd.emit_last = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.key_match) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = calt_pkg::EM_REC;
                        o_cmd.emit_last = 1'b1;
                        n_state = (i_stat.op == calt_pkg::OP_REMOVE) ? S_SH_RD : S_IDLE;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SH_RD: begin
                if (i_stat.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SH_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/compacting_array_list_table.sv =====
// Timing: an append is answered from S_APP once taken; a find reads the records in turn
//   from position 0, issuing each read in S_SCAN and comparing it in S_CHECK.
// List reads each record in S_LIST and emits it in S_LS_EM. Remove then compacts the table,
//   reading the next record in S_SH_RD and writing it one place down in S_SH_WR. One item at
//   a time: each record read is issued before its registered data is used.
// Reset clears the entry count and control only; records are undefined until written.
module compacting_array_list_table #(
    parameter int CAPACITY = calt_pkg::CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  calt_pkg::t_in_item  i_in_item,
    // result item channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output calt_pkg::t_out_item o_out_item
);

    // Commands from the sequencer, status back from the datapath
    calt_pkg::t_cmd  cmd;
    calt_pkg::t_stat stat;

    // In idle the sequencer dispatches on the arriving item's opcode,
    // which the datapath passes straight through in its status.
    calt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Records live in the RAM packed from position 0; the result register
    // lets a finished item wait while the sequencer gets on with the next.
    calt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

// ===== rtl/calt_check.sv =====
// Port-level checks for the compacting record table, bound to the top level.
module calt_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input calt_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input calt_pkg::t_out_item o_out_item
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // One item in flight: busy right after taking one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != calt_pkg::ST_OK)
        |-> o_out_item.last && (o_out_item.out_name_tag == '0)
            && (o_out_item.entry_index == '0))
        else $error("error result not single or not zeroed");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == calt_pkg::ST_EMPTY)
        |-> (o_out_item.out_key == '0) && (o_out_item.out_price_cents == '0))
        else $error("empty status carries data");

endmodule

bind compacting_array_list_table calt_check u_calt_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== dv/compacting_array_list_table_tb.sv =====
// Self-checking testbench for the compacting record table: directed and random items.
`timescale 1ns / 1ps

module compacting_array_list_table_tb;

    // Hold-off of the result side, taken once when this many items have gone in
    localparam int HOLD_AT   = 150;
    localparam int HOLD_LEN  = 700;
    // Settling time at the end: a full scan plus a full compaction, with margin
    localparam int SETTLE    = 4 * calt_pkg::CAPACITY + 16;
    localparam int N_ITEMS   = 380;

    typedef struct {
        calt_pkg::t_in_item item;
        bit                 drain;    // wait until every expected result is in
    } t_pending_op;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    calt_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    calt_pkg::t_out_item out_item;

    // Items still to be offered, and results still owed by the block
    t_pending_op         pending_ops[$];
    calt_pkg::t_out_item exp_results[$];

    // Keys the stimulus generator believes are stored, in table order
    logic signed [31:0] gen_keys[$];

    // Predicted table contents
    logic signed [31:0] tbl_key   [calt_pkg::CAPACITY];
    logic [63:0]        tbl_tag   [calt_pkg::CAPACITY];
    logic [31:0]        tbl_price [calt_pkg::CAPACITY];
    int                 tbl_count = 0;

    int n_errors   = 0;
    int n_accepted = 0;
    int n_results  = 0;

    compacting_array_list_table i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= 40) begin
            $display("tb: mismatch at result %0d: %s", n_results, what);
        end
    endtask

    // Apply one accepted item to the predicted table and queue the results it owes
    function automatic void table_apply(calt_pkg::t_in_item it);
        calt_pkg::t_out_item r;
        int                  hit;
        int                  i;
        r      = '0;
        r.last = 1'b1;
        hit    = -1;
        case (it.opcode)
            calt_pkg::OP_APPEND: begin
                if (tbl_count >= calt_pkg::CAPACITY) begin
                    r.status  = calt_pkg::ST_FULL;
                    r.out_key = it.key;
                end else begin
                    tbl_key[tbl_count]   = it.key;
                    tbl_tag[tbl_count]   = it.name_tag;
                    tbl_price[tbl_count] = it.price_cents;
                    r.status          = calt_pkg::ST_OK;
                    r.out_key         = it.key;
                    r.out_name_tag    = it.name_tag;
                    r.out_price_cents = it.price_cents;
                    r.entry_index     = 6'(tbl_count);
                    tbl_count++;
                end
                exp_results.push_back(r);
            end
            calt_pkg::OP_LIST: begin
                if (tbl_count == 0) begin
                    r.status = calt_pkg::ST_EMPTY;
                    exp_results.push_back(r);
                end else begin
                    for (i = 0; i < tbl_count; i++) begin
                        r.status          = calt_pkg::ST_OK;
                        r.out_key         = tbl_key[i];
                        r.out_name_tag    = tbl_tag[i];
                        r.out_price_cents = tbl_price[i];
                        r.entry_index     = 6'(i);
                        r.last            = (i == tbl_count - 1);
                        exp_results.push_back(r);
                    end
                end
            end
            default: begin
                // find and remove both report the first match
                for (i = 0; i < tbl_count; i++) begin
                    if (hit < 0 && tbl_key[i] == it.key) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    r.status  = calt_pkg::ST_MISS;
                    r.out_key = it.key;
                end else begin
                    r.status          = calt_pkg::ST_OK;
                    r.out_key         = tbl_key[hit];
                    r.out_name_tag    = tbl_tag[hit];
                    r.out_price_cents = tbl_price[hit];
                    r.entry_index     = 6'(hit);
                    if (it.opcode == calt_pkg::OP_REMOVE) begin
                        // close the gap: later records move down one place
                        for (i = hit; i + 1 < tbl_count; i++) begin
                            tbl_key[i]   = tbl_key[i + 1];
                            tbl_tag[i]   = tbl_tag[i + 1];
                            tbl_price[i] = tbl_price[i + 1];
                        end
                        tbl_count--;
                    end
                end
                exp_results.push_back(r);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers. The generator keeps its own list of stored keys so
    // that finds and removes mostly aim at records that exist.
    // ---------------------------------------------------------------------
    function automatic void queue_op(logic [1:0] op, logic signed [31:0] key,
                                     logic [63:0] tag, logic [31:0] price, bit drain);
        t_pending_op p;
        int          i;
        p.item.opcode      = op;
        p.item.key         = key;
        p.item.name_tag    = tag;
        p.item.price_cents = price;
        p.drain            = drain;
        pending_ops.push_back(p);
        if (op == calt_pkg::OP_APPEND && gen_keys.size() < calt_pkg::CAPACITY) begin
            gen_keys.push_back(key);
        end else if (op == calt_pkg::OP_REMOVE) begin
            for (i = 0; i < gen_keys.size(); i++) begin
                if (gen_keys[i] == key) begin
                    gen_keys.delete(i);
                    break;
                end
            end
        end
    endfunction

    // Small pool of keys, extremes included, so duplicates are common
    function automatic logic signed [31:0] pool_key();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4:       return 32'sd1;
            5:       return 32'sd7;
            6:       return 32'sd100;
            default: return 32'sh5A5A_5A5A;
        endcase
    endfunction

    function automatic logic signed [31:0] append_key();
        if ($urandom_range(0, 1) == 0) begin
            return pool_key();
        end
        return $urandom;
    endfunction

    function automatic logic signed [31:0] target_key();
        if (gen_keys.size() != 0 && $urandom_range(0, 3) != 0) begin
            return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
        end
        if ($urandom_range(0, 1) == 0) begin
            return pool_key();
        end
        return $urandom;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: offers items from pending_ops in bursts of random length with
    // random gaps. An item marked drain is held back until the block owes
    // nothing more.
    // ---------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk) begin : item_driver
        t_pending_op nxt;
        bit          may_send;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                table_apply(in_item);
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || in_ready) begin
                may_send = pending_ops.size() != 0 && gap_left == 0;
                if (may_send && pending_ops[0].drain) begin
                    may_send = !in_valid && exp_results.size() == 0;
                end
                if (may_send) begin
                    nxt = pending_ops.pop_front();
                    in_item  <= nxt.item;
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        // now and then a long burst with no idling at all
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                                  : $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left <= gap_left - 1;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: ready follows a randomly chosen mode that changes after a random-length phase,
    // plus one long hold-off so the block backs up and stalls its input.
    // ---------------------------------------------------------------------
    int rx_mode       = 0;
    int rx_phase_left = 0;
    int rx_cycle      = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
                out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                if (rx_phase_left == 0) begin
                    rx_mode       <= $urandom_range(0, 3);
                    rx_phase_left <= $urandom_range(16, 96);
                end else begin
                    rx_phase_left <= rx_phase_left - 1;
                end
                case (rx_mode)
                    0:       out_ready <= 1'b1;                          // always taking
                    1:       out_ready <= 1'($urandom_range(0, 1));      // half the time
                    2:       out_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
                    default: out_ready <= (rx_cycle % 3 == 0);           // periodic, on the cycle counter
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: every accepted result is checked against the oldest one owed
    // ---------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        calt_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (exp_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = exp_results.pop_front();
                if (out_item.status != want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              out_item.status, want.status));
                if (out_item.out_key != want.out_key)
                    report_mismatch($sformatf("key %0d, want %0d",
                                              out_item.out_key, want.out_key));
                if (out_item.out_name_tag != want.out_name_tag)
                    report_mismatch($sformatf("name tag %h, want %h",
                                              out_item.out_name_tag, want.out_name_tag));
                if (out_item.out_price_cents != want.out_price_cents)
                    report_mismatch($sformatf("price %0d, want %0d",
                                              out_item.out_price_cents, want.out_price_cents));
                if (out_item.entry_index != want.entry_index)
                    report_mismatch($sformatf("index %0d, want %0d",
                                              out_item.entry_index, want.entry_index));
                if (out_item.last != want.last)
                    report_mismatch($sformatf("last %0b, want %0b",
                                              out_item.last, want.last));
            end
            n_results <= n_results + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ---------------------------------------------------------------------
    initial begin
        int  seg;
        int  len;
        int  r;
        int  k;
        bit  drain;
        logic [1:0] op;

        // Directed: empty table, field extremes, duplicate keys, removal at
        // the front, middle and back, back to empty
        queue_op(calt_pkg::OP_LIST,   32'sd0, '0, '0, 1'b1);          // list of empty table
        queue_op(calt_pkg::OP_FIND,   32'sd5, '1, '1, 1'b0);          // miss on empty
        queue_op(calt_pkg::OP_REMOVE, 32'sd5, '0, '1, 1'b0);
        queue_op(calt_pkg::OP_APPEND, 32'sh8000_0000, '1, '1, 1'b0);
        queue_op(calt_pkg::OP_APPEND, 32'sh7FFF_FFFF, '0, '0, 1'b0);
        queue_op(calt_pkg::OP_APPEND, -32'sd1, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA,
                 1'b0);
        queue_op(calt_pkg::OP_APPEND, 32'sd0, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555,
                 1'b0);
        queue_op(calt_pkg::OP_APPEND, -32'sd1, 64'h0123_4567_89AB_CDEF, 32'd12345, 1'b0);
        queue_op(calt_pkg::OP_LIST,   32'sd0, '0, '0, 1'b0);
        queue_op(calt_pkg::OP_FIND,   -32'sd1, '0, '0, 1'b0);         // first of two duplicates
        queue_op(calt_pkg::OP_FIND,   32'sh7FFF_FFFF, '0, '0, 1'b0);
        queue_op(calt_pkg::OP_FIND,   32'sd42, '0, '0, 1'b0);         // key absent
        queue_op(calt_pkg::OP_REMOVE, -32'sd1, '0, '0, 1'b0);         // middle, shifts the rest
        queue_op(calt_pkg::OP_FIND,   -32'sd1, '0, '0, 1'b0);         // now the later duplicate
        queue_op(calt_pkg::OP_REMOVE, 32'sh8000_0000, '0, '0, 1'b0);  // front
        queue_op(calt_pkg::OP_REMOVE, 32'sd42, '0, '0, 1'b0);         // remove, key absent
        queue_op(calt_pkg::OP_LIST,   32'sd0, '0, '0, 1'b0);
        queue_op(calt_pkg::OP_REMOVE, -32'sd1, '0, '0, 1'b0);         // back
        queue_op(calt_pkg::OP_REMOVE, 32'sd0, '0, '0, 1'b0);
        queue_op(calt_pkg::OP_REMOVE, 32'sh7FFF_FFFF, '0, '0, 1'b0);  // table empty again
        queue_op(calt_pkg::OP_LIST,   32'sd0, '0, '0, 1'b0);

        // Fill to capacity with random records, then push past it
        drain = 1'b1;
        while (gen_keys.size() < calt_pkg::CAPACITY) begin
            queue_op(calt_pkg::OP_APPEND, append_key(), {$urandom, $urandom}, $urandom,
                     drain);
            drain = 1'b0;
        end
        for (k = 0; k < 3; k++) begin
            queue_op(calt_pkg::OP_APPEND, append_key(), {$urandom, $urandom}, $urandom,
                     1'b0);
        end
        queue_op(calt_pkg::OP_LIST, $urandom, {$urandom, $urandom}, $urandom, 1'b0);
        queue_op(calt_pkg::OP_FIND, gen_keys[calt_pkg::CAPACITY - 1],
                 {$urandom, $urandom}, $urandom, 1'b0);
        queue_op(calt_pkg::OP_REMOVE, gen_keys[0], {$urandom, $urandom}, $urandom, 1'b0);

        // Random segments: growing, shrinking and mixed, so the table swings
        // between empty and full; a segment sometimes starts after a drain
        while (pending_ops.size() < N_ITEMS) begin
            seg   = $urandom_range(0, 2);
            len   = $urandom_range(15, 40);
            drain = ($urandom_range(0, 2) == 0);
            for (k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                case (seg)
                    0:       op = (r < 80) ? calt_pkg::OP_APPEND
                                 : (r < 85) ? calt_pkg::OP_LIST
                                 : (r < 93) ? calt_pkg::OP_FIND : calt_pkg::OP_REMOVE;
                    1:       op = (r < 15) ? calt_pkg::OP_APPEND
                                 : (r < 20) ? calt_pkg::OP_LIST
                                 : (r < 40) ? calt_pkg::OP_FIND : calt_pkg::OP_REMOVE;
                    default: op = (r < 35) ? calt_pkg::OP_APPEND
                                 : (r < 45) ? calt_pkg::OP_LIST
                                 : (r < 72) ? calt_pkg::OP_FIND : calt_pkg::OP_REMOVE;
                endcase
                // tag and price are random on every opcode; only append uses them
                queue_op(op, (op == calt_pkg::OP_APPEND) ? append_key() : target_key(),
                         {$urandom, $urandom}, $urandom, drain);
                drain = 1'b0;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // All items in and every result back, then let the block settle
        while (pending_ops.size() != 0 || in_valid || exp_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);

        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
